/* rtl/dwd_pkg.sv */
// ----------------------------------------------------------------------------
// dwd_pkg
// Shared types and constants for the delimited word de-duplicator.
// ----------------------------------------------------------------------------
`default_nettype none
package dwd_pkg;
  localparam int unsigned WordLenDef  = 32;
  localparam int unsigned MaxWordsDef = 16;
  localparam logic [7:0]  SepByte     = 8'd124;
  localparam logic [7:0]  NlByte      = 8'd10;
  localparam logic [7:0]  DelimReset  = 8'd124;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StTrunc = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP_LEN,
    S_CMP_RD,
    S_CMP_CHK,
    S_SEP,
    S_EMIT_RD,
    S_EMIT,
    S_NL,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

/* rtl/delimited_word_dedup.sv */
// ----------------------------------------------------------------------------
// delimited_word_dedup
// Splits a byte stream into words on a delimiter and drops repeats per line.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i/in_ready_o, in_byte_i, line_end_i
// out     | output    | out_valid_o/out_ready_i, out_byte_o, run_last_o, status_o
// cfg     | input     | cfg_we_i, cfg_wdata_i
// A plain byte is written to the word buffer while it has room. A word end runs
// the length check against each stored word in turn, plus a read and a check
// per compared byte through the single store read port; a new word then gets
// the separator and a read and an emit per byte; a line end adds the newline.
// Reset clears control state only; no clearing pass is needed.
// An output stall holds the sequencer; input is taken only when idle.
`default_nettype none
module delimited_word_dedup import dwd_pkg::*; #(
  parameter int unsigned WORD_LEN  = WordLenDef,
  parameter int unsigned MAX_WORDS = MaxWordsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       line_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic [1:0]      status_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);
  localparam int unsigned LW = $clog2(WORD_LEN + 1);
  localparam int unsigned IW = $clog2(WORD_LEN);
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned SW = $clog2(MAX_WORDS);
  localparam int unsigned AW = SW + IW;

  state_e state_q, state_d;
  logic [7:0]    delim_q;
  logic [LW-1:0] wlen_q, wlen_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          first_q, first_d, trunc_q, trunc_d, last_q, last_d;
  logic [CW-1:0] wi_q, wi_d;
  logic [LW-1:0] j_q, j_d;
  logic [1:0]    st_q, st_d;
  logic          nst_q, nst_d;

  logic [7:0] wbuf [WORD_LEN];
  logic [7:0] store [MAX_WORDS*WORD_LEN];
  logic [LW-1:0] slen [MAX_WORDS];
  logic [7:0] wbuf_rd_q, store_rd_q;

  logic          buf_we, st_we, len_we;
  logic [IW-1:0] buf_wa, rd_j;
  logic [7:0]    buf_wd;
  logic [AW-1:0] st_wa, st_ra;
  logic          rd_en;
  logic [SW-1:0] wi_idx, cnt_idx;

  assign wi_idx  = wi_q[SW-1:0];
  assign cnt_idx = cnt_q[SW-1:0];
  assign rd_j    = j_q[IW-1:0];
  assign st_ra   = AW'(wi_idx) * AW'(WORD_LEN) + AW'(rd_j);
  assign st_wa   = AW'(cnt_idx) * AW'(WORD_LEN) + AW'(rd_j);

  always_ff @(posedge clk_i) begin
    if (buf_we) wbuf[buf_wa] <= buf_wd;
    if (st_we) store[st_wa] <= wbuf_rd_q;
    if (len_we) slen[cnt_idx] <= wlen_q;
    if (rd_en) begin
      wbuf_rd_q  <= wbuf[rd_j];
      store_rd_q <= store[st_ra];
    end
  end

  logic in_acc, is_delim, emit_ok;
  assign in_acc   = in_valid_i && in_ready_o;
  assign is_delim = (in_byte_i == delim_q);
  assign emit_ok  = !out_valid_o || out_ready_i;

  logic       o_v_d, o_l_d;
  logic [7:0] o_b_d;
  logic [1:0] o_s_d;
  logic       ov_q, ol_q;
  logic [7:0] ob_q;
  logic [1:0] os_q;

  always_comb begin
    state_d = state_q; wlen_d = wlen_q; cnt_d = cnt_q; first_d = first_q;
    trunc_d = trunc_q; last_d = last_q; wi_d = wi_q; j_d = j_q;
    st_d = st_q; nst_d = nst_q;
    buf_we = 1'b0; buf_wa = wlen_q[IW-1:0]; buf_wd = in_byte_i;
    st_we = 1'b0; len_we = 1'b0; rd_en = 1'b0;
    o_v_d = 1'b0; o_b_d = in_byte_i; o_s_d = StOk; o_l_d = 1'b0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d = line_end_i;
          if (in_byte_i != NlByte && !is_delim) begin
            if (wlen_q < LW'(WORD_LEN)) begin
              buf_we = 1'b1;
              wlen_d = wlen_q + 1'b1;
            end else begin
              trunc_d = 1'b1;
            end
          end
          if ((in_byte_i != NlByte && is_delim) || line_end_i) begin
            wi_d = '0; j_d = '0;
            state_d = S_CMP_LEN;
          end
        end
      end
      S_CMP_LEN: begin
        j_d = '0;
        if (wlen_q == '0) begin
          trunc_d = 1'b0;
          state_d = last_q ? S_NL : S_IDLE;
        end else if (wi_q >= cnt_q) begin
          st_d = (cnt_q >= CW'(MAX_WORDS)) ? StFull : (trunc_q ? StTrunc : StOk);
          nst_d = (cnt_q < CW'(MAX_WORDS));
          state_d = first_q ? S_SEP : S_EMIT_RD;
        end else if (slen[wi_idx] != wlen_q) begin
          wi_d = wi_q + 1'b1;
        end else begin
          state_d = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        rd_en = 1'b1;
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (wbuf_rd_q != store_rd_q) begin
          wi_d = wi_q + 1'b1; j_d = '0;
          state_d = S_CMP_LEN;
        end else if (j_q + 1'b1 == wlen_q) begin
          wlen_d = '0; trunc_d = 1'b0;
          state_d = last_q ? S_NL : S_IDLE;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_CMP_RD;
        end
      end
      S_SEP: begin
        if (emit_ok) begin
          o_v_d = 1'b1; o_b_d = SepByte; o_s_d = st_q;
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        rd_en = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          o_v_d = 1'b1; o_b_d = wbuf_rd_q; o_s_d = st_q;
          st_we = nst_q;
          if (j_q + 1'b1 == wlen_q) begin
            o_l_d = !last_q;
            len_we = nst_q;
            if (nst_q) cnt_d = cnt_q + 1'b1;
            first_d = 1'b1; wlen_d = '0; trunc_d = 1'b0;
            state_d = last_q ? S_NL : S_IDLE;
          end else begin
            j_d = j_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      S_NL: begin
        if (emit_ok) begin
          o_v_d = 1'b1; o_b_d = NlByte; o_l_d = 1'b1;
          cnt_d = '0; first_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; delim_q <= DelimReset; wlen_q <= '0; cnt_q <= '0;
      first_q <= 1'b0; trunc_q <= 1'b0; last_q <= 1'b0; wi_q <= '0; j_q <= '0;
      st_q <= StOk; nst_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; wlen_q <= wlen_d; cnt_q <= cnt_d; first_q <= first_d;
      trunc_q <= trunc_d; last_q <= last_d; wi_q <= wi_d; j_q <= j_d;
      st_q <= st_d; nst_q <= nst_d;
      if (cfg_we_i) delim_q <= cfg_wdata_i;
      if (o_v_d) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_v_d) begin
      ob_q <= o_b_d; ol_q <= o_l_d; os_q <= o_s_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign run_last_o  = ol_q;
  assign status_o    = os_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_WORDS)) else $error("store count overflow");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wlen_q <= LW'(WORD_LEN)) else $error("word length overflow");
  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NL && emit_ok) |=> (cnt_q == '0 && !first_q))
    else $error("line end did not clear store");
`endif
endmodule
`default_nettype wire
